FILE: hw/rtl/skf_pkg.sv
package skf_pkg;

    // Fixed field widths.
    localparam int DATA_W    = 32;
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 2;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = GAIN_W + DIFF_W;
    localparam int SUM_W     = DATA_W + 3;

    // The divider produces one quotient bit per step.
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_BITS;
    localparam logic [PROD_W-1:0] GAIN_HALF = PROD_W'(1) << (GAIN_BITS - 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL_GAIN,
        ST_MUL_COV,
        ST_COMMIT
    } skf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic mul_en;
        logic mul_cov;
        logic est_en;
        logic commit;
    } skf_cmd_t;

endpackage

FILE: hw/rtl/skf_controller.sv
module skf_controller
    import skf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output skf_cmd_t cmd
);

    skf_state_t             state_reg;
    skf_state_t             state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_COV;
            end
            ST_MUL_COV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_cov = 1'b1;
                cmd.est_en  = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // The state doubles as the output register, so it may only
                // change once the previous result has been taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = (state_reg == ST_DIV) ? cnt_reg + DIV_CNT_W'(1) : '0;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/skf_datapath.sv
module skf_datapath
    import skf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  skf_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] measurement,
    input  logic                    cfg_write_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]       cfg_data,
    output logic signed [DATA_W-1:0] filtered_estimate,
    output logic [DATA_W-1:0]       error_variance
);

    localparam logic [DATA_W-1:0] Q_RESET = DATA_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [DATA_W-1:0] R_RESET = DATA_W'(1 << (FRAC_BITS - 1));
    localparam logic [DATA_W-1:0] P_RESET = DATA_W'(1 << FRAC_BITS);

    // Configuration and filter state.
    logic [DATA_W-1:0]  q_reg;
    logic [DATA_W-1:0]  r_reg;
    logic [DATA_W-1:0]  est_reg;
    logic [DATA_W-1:0]  cov_reg;

    // Working registers.
    logic [DATA_W-1:0]  meas_reg;
    logic [DATA_W-1:0]  pp_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [GAIN_W-1:0]  quo_reg;
    logic [DIFF_W-1:0]  absd_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DATA_W-1:0]  ne_reg;

    logic [DEN_W-1:0]   pp_sum;
    logic [DATA_W-1:0]  pp_sat;
    logic [DIFF_W-1:0]  diff;
    logic               ge;
    logic [REM_W-1:0]   rem_sub;
    logic [GAIN_W-1:0]  gain;
    logic [GAIN_W-1:0]  mul_a;
    logic [DIFF_W-1:0]  mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  rnd;
    logic [DIFF_W-1:0]  corr_mag;
    logic [SUM_W-1:0]   corr;
    logic [SUM_W-1:0]   est_sum;
    logic [DATA_W-1:0]  est_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= Q_RESET;
            r_reg   <= R_RESET;
            est_reg <= '0;
            cov_reg <= P_RESET;
        end
        else
        begin
            if (cfg_write_en && cfg_index == REG_PROCESS_NOISE)
            begin
                q_reg <= cfg_data;
            end
            if (cfg_write_en && cfg_index == REG_MEASUREMENT_NOISE)
            begin
                r_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                est_reg <= ne_reg;
                cov_reg <= rnd[GAIN_BITS +: DATA_W];
            end
        end
    end

    always_comb
    begin
        pp_sum  = {1'b0, cov_reg} + {1'b0, q_reg};
        pp_sat  = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
        diff    = {meas_reg[DATA_W-1], meas_reg} - {est_reg[DATA_W-1], est_reg};
        ge      = rem_reg >= {1'b0, den_reg};
        rem_sub = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        // A zero denominator only happens with P + Q and R both zero.
        gain    = (den_reg == '0) ? '0 : quo_reg;
        mul_a   = cmd.mul_cov ? GAIN_ONE - gain : gain;
        mul_b   = cmd.mul_cov ? {1'b0, pp_reg} : absd_reg;
        mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
        // One rounding adder serves both products.
        rnd      = prod_reg + GAIN_HALF;
        corr_mag = rnd[GAIN_BITS +: DIFF_W];
        corr     = neg_reg ? -{2'b0, corr_mag} : {2'b0, corr_mag};
        est_sum  = {{3{est_reg[DATA_W-1]}}, est_reg} + corr;
        if (!est_sum[SUM_W-1] && est_sum[SUM_W-2:DATA_W-1] != '0)
        begin
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (est_sum[SUM_W-1] && est_sum[SUM_W-2:DATA_W-1] != '1)
        begin
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            est_sat = est_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= measurement;
            pp_reg   <= pp_sat;
        end
        if (cmd.prep)
        begin
            den_reg  <= {1'b0, pp_reg} + {1'b0, r_reg};
            rem_reg  <= {2'b0, pp_reg};
            quo_reg  <= '0;
            neg_reg  <= diff[DIFF_W-1];
            absd_reg <= diff[DIFF_W-1] ? -diff : diff;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_W-2:0], ge};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.est_en)
        begin
            ne_reg <= est_sat;
        end
    end

    assign filtered_estimate = est_reg;
    assign error_variance    = cov_reg;

endmodule

FILE: hw/rtl/scalar_kalman_filter.sv
// out_valid rises once an accepted request has been committed. If the previous
// result has not been taken by the commit step, the commit holds until it is.
// A new request is accepted only after the last one commits; the 17-step radix-2
// gain divider and one shared 17x33 multiplier used twice set the pace.
// Reset (rst_n low, asynchronous): estimate 0, covariance 1.0, Q 0.1, R 0.5.
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] measurement,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] filtered_estimate,
    output logic [DATA_W-1:0]        error_variance,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    // The controller walks each request through a fixed sequence:
    // load the measurement and the saturated prediction P + Q, form the
    // denominator and |m - e|, run the restoring divider for the gain one
    // quotient bit per cycle, multiply K * |m - e|, then multiply
    // (1 - K) * (P + Q) while the rounded estimate correction is saturated,
    // and finally commit the new estimate and covariance.
    //
    // The filter state registers are also the result registers, so a new
    // request can be accepted while the last result is still waiting; the
    // commit step simply holds until that result has been taken.

    skf_cmd_t cmd;

    skf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    skf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .measurement       (measurement),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .filtered_estimate (filtered_estimate),
        .error_variance    (error_variance)
    );

    // A request is taken only when no other one is in progress.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another was in progress");

    // New results may never overwrite a result that has not been taken.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result overwritten before it was taken");

    // Only one datapath step is active in any cycle.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.mul_en, cmd.commit}))
        else $error("overlapping datapath commands");

    // The estimate and variance outputs only change on a commit.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.commit) |-> ($stable(filtered_estimate) && $stable(error_variance)))
        else $error("filter state changed outside a commit");

endmodule
